// ===== hdl/atb_pkg.sv =====
// shared types and constants for the alarm timer bank
`timescale 1ns / 1ps

package atb_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int CNT_W     = 16;
  localparam int MASK_W    = 16;
  localparam int SLOT_W    = 4;
  localparam int CMD_W     = 3;

  localparam logic [CMD_W-1:0] CMD_TICK       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REGISTER   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UNREGISTER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP       = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd5;

  // command token passed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  duration;
    logic [MASK_W-1:0] mask;
    logic              ticking;
    logic              expired;
    logic              registered;
    logic              err;
  } atb_token_t;

endpackage

// ===== hdl/atb_req_if.sv =====
// command channel interface of the alarm timer bank
`timescale 1ns / 1ps

interface atb_req_if import atb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  duration;

  modport source (output valid, command, slot, duration, input ready);
  modport sink   (input valid, command, slot, duration, output ready);
endinterface

// ===== hdl/atb_rsp_if.sv =====
// result channel interface of the alarm timer bank
`timescale 1ns / 1ps

interface atb_rsp_if import atb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_ticking;
  logic              is_expired;
  logic              is_registered;
  logic [MASK_W-1:0] expired_now_mask;
  logic              error;

  modport source (output valid, is_ticking, is_expired, is_registered, expired_now_mask,
                  error, input ready);
  modport sink   (input valid, is_ticking, is_expired, is_registered, expired_now_mask,
                  error, output ready);
endinterface

// ===== hdl/alarm_timer_bank_top.sv =====
// top level of the alarm timer bank: a row of slot cells and the result register
`timescale 1ns / 1ps

// usage
// - req carries one command item (command, slot, duration); rsp returns one
//   result item per command (flags of the addressed slot, tick expiry mask, error)
// - each slot lives in its own cell; an accepted item becomes a token that
//   walks the row one cell per cycle, and each cell applies it to its slot
//   as it passes (tick decrements, addressed commands act on one cell)
// - one item at a time: a new item is accepted only after the token of the
//   last one has left the row; only one token is in the row at a time
// - req.ready is low while a token is in the row; it is high again while a
//   finished result still waits in the result register
// - if rsp is stalled when the next token reaches the end of the row, the
//   whole row holds until the result register frees up
// - reset (rst, synchronous) clears all slots: no slot registered, no
//   ticking, nothing expired, counts zero; the row and rsp come up empty
// - slot indexes of SLOTS and above are ignored except that unregister flags
//   error; the expiry mask shows slots 0 to 15 only
module alarm_timer_bank_top import atb_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic       clk,
  input logic       rst,
  atb_req_if.sink   req,
  atb_rsp_if.source rsp
);

  atb_token_t tok [0:SLOTS];
  logic       busy;
  logic       en;
  logic       accept;
  logic       take_out;
  logic       rsp_valid;

  // row holds only when the final token cannot move into the result register
  assign take_out = tok[SLOTS].valid && (!rsp_valid || rsp.ready);
  assign en       = !(tok[SLOTS].valid && !take_out);

  assign req.ready = !busy;
  assign accept    = req.valid && req.ready;

  // inject the command token; error starts set for unregister and is
  // cleared by the addressed cell if it was registered
  always_comb begin
    tok[0]            = '0;
    tok[0].valid      = accept;
    tok[0].command    = req.command;
    tok[0].slot       = req.slot;
    tok[0].duration   = req.duration;
    tok[0].err        = (req.command == CMD_UNREGISTER);
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    atb_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  // busy from acceptance until the token leaves the row
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (take_out) begin
      busy <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      rsp.is_ticking       <= tok[SLOTS].ticking;
      rsp.is_expired       <= tok[SLOTS].expired;
      rsp.is_registered    <= tok[SLOTS].registered;
      rsp.expired_now_mask <= tok[SLOTS].mask;
      rsp.error            <= tok[SLOTS].err;
    end
  end

  assign rsp.valid = rsp_valid;

  // valid flags of the tokens along the row
  logic [SLOTS:0] tok_valid_vec;
  for (genvar j = 0; j <= SLOTS; j++) begin : g_vld
    assign tok_valid_vec[j] = tok[j].valid;
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid_vec[SLOTS:1]))
    else $error("more than one token in the cell row");

  a_token_arrives: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##SLOTS tok[SLOTS].valid)
    else $error("token did not reach the end of the row in time");

  a_busy_covers_token: assert property (@(posedge clk) disable iff (rst)
    (|tok_valid_vec[SLOTS:1]) |-> busy)
    else $error("token in the row while not busy");

endmodule

// ===== hdl/atb_cell.sv =====
// one alarm slot: holds its count and flags, acts on the passing token
`timescale 1ns / 1ps

module atb_cell import atb_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  atb_token_t tok_in,
  output atb_token_t tok_out
);

  localparam logic              ADDRESSABLE = (IDX < (1 << SLOT_W));
  localparam logic [SLOT_W-1:0] MY_SLOT     = SLOT_W'(IDX);
  localparam logic [MASK_W-1:0] MY_BIT      = MASK_W'(64'(1) << IDX);

  logic [CNT_W-1:0] cnt, cnt_next;
  logic             ticking, ticking_next;
  logic             expired, expired_next;
  logic             registered, registered_next;
  atb_token_t       tok_next;
  logic             hit;

  assign hit = tok_in.valid && ADDRESSABLE && (tok_in.slot == MY_SLOT);

  always_comb begin
    cnt_next        = cnt;
    ticking_next    = ticking;
    expired_next    = expired;
    registered_next = registered;
    tok_next        = tok_in;
    if (tok_in.valid && tok_in.command == CMD_TICK) begin
      if (registered && ticking) begin
        cnt_next = cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          ticking_next  = 1'b0;
          expired_next  = 1'b1;
          tok_next.mask = tok_in.mask | MY_BIT;
        end
      end
    end else if (hit) begin
      case (tok_in.command)
        CMD_REGISTER: begin
          ticking_next    = 1'b0;
          expired_next    = 1'b0;
          registered_next = 1'b1;
        end
        CMD_UNREGISTER: begin
          if (registered) begin
            registered_next = 1'b0;
            tok_next.err    = 1'b0;
          end
        end
        CMD_START: begin
          cnt_next     = tok_in.duration;
          ticking_next = 1'b1;
          expired_next = 1'b0;
        end
        CMD_STOP: begin
          ticking_next = 1'b0;
        end
        default: begin
        end
      endcase
      if (tok_in.command inside {CMD_REGISTER, CMD_UNREGISTER, CMD_START, CMD_STOP,
                                 CMD_QUERY}) begin
        tok_next.ticking    = ticking_next;
        tok_next.expired    = expired_next;
        tok_next.registered = registered_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt           <= '0;
      ticking       <= 1'b0;
      expired       <= 1'b0;
      registered    <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (en) begin
      cnt        <= cnt_next;
      ticking    <= ticking_next;
      expired    <= expired_next;
      registered <= registered_next;
      tok_out    <= tok_next;
    end
  end

endmodule
